/* sv/assert_macros.svh */
// Assertion macros shared by the block level meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define PBL_NEVER(lbl, expr, msg) `PBL_ASSERT(lbl, !(expr), msg)

`endif

/* sv/pbl_pkg.sv */
// Package with widths, threshold tables and shared types of the block level meter.
`default_nettype none

package pbl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 17;
  localparam int SUM_W    = 33;
  localparam int FRAC_W   = 24;
  localparam int MEAN_W   = SUM_W + FRAC_W;
  localparam int LEVEL_W  = 8;
  localparam int K_W      = 7;
  localparam int DB_STEPS = 128;
  localparam int THR_W    = 48;
  localparam int DIV_CNT_W = $clog2(MEAN_W);
  localparam logic [K_W-1:0] K_MAX = K_W'(DB_STEPS - 1);

  typedef logic [THR_W-1:0] thr_tab_t [DB_STEPS];

  typedef struct packed {
    logic accept;
    logic last;
  } acc_ctrl_t;

  localparam logic [THR_W-1:0] FRAC_Q24 [20] = '{
    48'd16777216, 48'd18824346, 48'd21121264, 48'd23698447, 48'd26590095,
    48'd29834578, 48'd33474947, 48'd37559508, 48'd42142461, 48'd47284619,
    48'd53054215, 48'd59527809, 48'd66791300, 48'd74941071, 48'd84085265,
    48'd94345219, 48'd105857077, 48'd118773593, 48'd133266164, 48'd149527095
  };

  // Threshold for level d >= 0: FRAC_Q24[d mod 20] times 10 to the d/20.
  function automatic thr_tab_t build_thr_pos();
    thr_tab_t    tab;
    logic [63:0] pw;
    int          r;
    pw = 64'd1;
    r  = 0;
    for (int j = 0; j < DB_STEPS; j++) begin
      tab[j] = THR_W'(64'(FRAC_Q24[r]) * pw);
      if (r == 19) begin
        r  = 0;
        pw = pw * 64'd10;
      end else begin
        r = r + 1;
      end
    end
    return tab;
  endfunction

  // Largest integer mean that still lies at or below the threshold of level -u.
  function automatic thr_tab_t build_thr_neg();
    thr_tab_t    tab;
    logic [63:0] pw;
    logic [63:0] quo;
    logic [63:0] trial;
    int          r;
    pw = 64'd1;
    r  = 0;
    for (int u = 0; u < DB_STEPS; u++) begin
      quo = 64'd0;
      for (int b = 31; b >= 0; b--) begin
        trial = quo | (64'd1 << b);
        if (trial * pw <= 64'(FRAC_Q24[r])) begin
          quo = trial;
        end
      end
      tab[u] = THR_W'(quo);
      if (r == 0) begin
        r  = 19;
        pw = pw * 64'd10;
      end else begin
        r = r - 1;
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_POS = build_thr_pos();
  localparam thr_tab_t THR_NEG = build_thr_neg();

endpackage

`default_nettype wire

/* sv/pbl_sub.sv */
// Shared subtract and compare unit used by the divider and the level search.
`default_nettype none

module pbl_sub #(
  parameter int W = 57
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic              ge_o,
  output logic [W-1:0]      diff_o
);

  logic [W:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~full[W];
  assign diff_o = full[W-1:0];

endmodule

`default_nettype wire

/* sv/pbl_accum.sv */
// Saturating magnitude sum and capped sample count of the current block.
`default_nettype none

module pbl_accum
  import pbl_pkg::*;
#(
  parameter int MAX_SAMPLES = 131072,
  parameter int CNT_W       = 18
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire acc_ctrl_t        ctrl_i,
  input  wire logic [MAG_W-1:0] mag_i,
  output logic [SUM_W-1:0]      sum_nxt_o,
  output logic [CNT_W-1:0]      cnt_nxt_o
);

  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W:0]   sum_add;
  logic             take;

  assign take    = ctrl_i.accept && (cnt_q < CNT_W'(MAX_SAMPLES));
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(mag_i);

  always_comb begin
    sum_nxt_o = sum_q;
    cnt_nxt_o = cnt_q;
    if (take) begin
      sum_nxt_o = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      cnt_nxt_o = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (ctrl_i.accept && ctrl_i.last) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_nxt_o;
      cnt_q <= cnt_nxt_o;
    end
  end

endmodule

`default_nettype wire

/* sv/pcm_block_level_db.sv */
// Sequence: after the last sample of a block transfers, a restoring division forms the mean,
// the threshold search then walks one dB at a time up to the 127 dB bound, and out_valid_o
// rises together with the registered level; a zero sum skips the division and the search.
// Throughput: one sample per cycle inside a block; after the last sample the input stalls
// while the shared subtract unit runs the restoring division and the threshold
// search, and further while a finished level waits behind a stalled output.
// Reset clears the running sum, the count, the sequencer and the output valid.
`default_nettype none

`include "assert_macros.svh"

module pcm_block_level_db
  import pbl_pkg::*;
#(
  parameter int MAX_SAMPLES = 131072
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       last_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  output logic signed [LEVEL_W-1:0]       level_db_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SRCH = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [MEAN_W-1:0]    q_q, q_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0]     div_q, div_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic [K_W-1:0]       k_q, k_d;
  logic                 neg_q, neg_d;
  logic signed [LEVEL_W-1:0] level_q, level_d;
  logic                 out_valid_q, out_valid_d;

  acc_ctrl_t            acc_ctrl;
  logic signed [MAG_W-1:0] sample_x;
  logic [MAG_W-1:0]     mag;
  logic [SUM_W-1:0]     sum_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 in_xfer;
  logic                 out_load;

  logic [MEAN_W-1:0]    sub_a, sub_b, sub_diff;
  logic                 sub_ge;
  logic [CNT_W:0]       div_a;
  logic [K_W-1:0]       idx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign sample_x = MAG_W'(sample_i);
  assign mag      = sample_x[MAG_W-1] ? MAG_W'(-sample_x) : MAG_W'(sample_x);

  assign acc_ctrl.accept = in_xfer;
  assign acc_ctrl.last   = last_i;

  pbl_accum #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .CNT_W      (CNT_W)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .mag_i    (mag),
    .sum_nxt_o(sum_nxt),
    .cnt_nxt_o(cnt_nxt)
  );

  assign div_a = {rem_q, q_q[MEAN_W-1]};
  assign idx   = k_q + K_W'(1);

  always_comb begin
    if (state_q == ST_SRCH) begin
      if (neg_q) begin
        sub_a = MEAN_W'(THR_NEG[idx]);
        sub_b = q_q;
      end else begin
        sub_a = q_q;
        sub_b = MEAN_W'(THR_POS[idx]);
      end
    end else begin
      sub_a = MEAN_W'(div_a);
      sub_b = MEAN_W'(div_q);
    end
  end

  pbl_sub #(
    .W(MEAN_W)
  ) u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .ge_o  (sub_ge),
    .diff_o(sub_diff)
  );

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    q_d     = q_q;
    rem_d   = rem_q;
    div_d   = div_q;
    step_d  = step_q;
    k_d     = k_q;
    neg_d   = neg_q;
    level_d = level_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && last_i) begin
          q_d    = {sum_nxt, {FRAC_W{1'b0}}};
          rem_d  = '0;
          div_d  = cnt_nxt;
          step_d = '0;
          k_d    = '0;
          neg_d  = 1'b0;
          state_d = (sum_nxt == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = sub_ge ? sub_diff[CNT_W-1:0] : div_a[CNT_W-1:0];
        q_d    = {q_q[MEAN_W-2:0], sub_ge};
        step_d = step_q + DIV_CNT_W'(1);
        if (step_q == DIV_CNT_W'(MEAN_W - 1)) begin
          neg_d   = (q_d[MEAN_W-1:FRAC_W] == '0);
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (k_q != K_MAX && sub_ge) begin
          k_d = idx;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (neg_q) begin
      level_d = -LEVEL_W'(signed'({1'b0, k_q}));
    end else begin
      level_d = LEVEL_W'(signed'({1'b0, k_q}));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      k_q         <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      k_q         <= k_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    div_q <= div_d;
    if (out_load) begin
      level_q <= level_d;
    end
  end

  assign level_db_o  = level_q;
  assign out_valid_o = out_valid_q;

  `PBL_ASSERT(a_rem_below_div, (state_q == ST_SRCH) |-> (rem_q < div_q),
              "division remainder is not below the sample count")
  `PBL_ASSERT(a_neg_mean_small, (state_q == ST_SRCH && neg_q) |-> (q_q[MEAN_W-1:FRAC_W] == '0),
              "negative search entered with a mean of at least one")
  `PBL_ASSERT(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE),
              "output transfer offered without a finished computation")
  `PBL_NEVER(a_div_nonzero, (state_q == ST_DIV) && (div_q == '0),
             "division started with a zero sample count")

endmodule

`default_nettype wire
